// ===== rtl/bbfe_pkg.sv =====
// Shared types and constants for the byte buffer frame extractor.
// Used by bbfe_front, bbfe_back and byte_buffer_frame_extractor; no dependencies.
package bbfe_pkg;

  // Each delimiter pattern holds up to this many bytes in its 32-bit register.
  localparam int PATTERN_BYTES = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 3;

  // Command codes.
  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;
  localparam logic [1:0] CMD_EXTRACT = 2'd3;

  // Extraction rules.
  localparam logic [2:0] RULE_ALL       = 3'd0;
  localparam logic [2:0] RULE_HEAD_TAIL = 3'd1;
  localparam logic [2:0] RULE_HEAD_LEN  = 3'd2;
  localparam logic [2:0] RULE_TAIL      = 3'd3;
  localparam logic [2:0] RULE_LEN       = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RULE_MODE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_PATTERN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_PATTERN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_LENGTH  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LENGTH = 3'd5;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] in_byte;
    logic [6:0] remove_count;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_found;
    logic       last;
    logic       overflow_dropped;
    logic [6:0] fill_level;
  } result_t;

  typedef struct packed {
    logic [2:0]  rule_mode;
    logic [31:0] head_pattern;
    logic [2:0]  head_length;
    logic [31:0] tail_pattern;
    logic [2:0]  tail_length;
    logic [6:0]  frame_length;
  } cfg_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } queue_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_RD,
    ST_CMP,
    ST_ERD,
    ST_EOUT
  } back_state_t;

endpackage

// ===== rtl/bbfe_front.sv =====
// Command front end: a two-entry queue between the start/busy port and the back end.
// Depends on bbfe_pkg.
module bbfe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bbfe_pkg::cmd_item_t in_item,
  output bbfe_pkg::queue_head_t head,
  input  logic                pop
);
  import bbfe_pkg::*;

  cmd_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       do_pop;

  assign busy   = (count == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.item  = entry[rd_ptr];

  // Entries are payload only; the pointers and count carry the state.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // The queue never holds more than two transfers.
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("front queue count out of range");
  // A pop is only taken from a non-empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> head.valid || !do_pop)
    else $error("pop from empty queue");
  // With the queue full and no pop, the count stays full.
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !pop) |=> count == 2'd2)
    else $error("full queue lost an entry");

endmodule

// ===== rtl/bbfe_back.sv =====
// Back end: byte store, pointer/fill state, pattern search sequencer and result register.
// Depends on bbfe_pkg; takes commands from bbfe_front.
module bbfe_back #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bbfe_pkg::cfg_t        cfg,
  input  bbfe_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  result_valid,
  output bbfe_pkg::result_t     result
);
  import bbfe_pkg::*;

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int CW = ((FW > 7) ? FW : 7) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUF_DEPTH);

  logic [7:0]    mem [BUF_DEPTH];
  logic [7:0]    rdata;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;

  back_state_t state, state_next;
  logic [AW-1:0] start_ptr, start_ptr_next;
  logic [FW-1:0] fill, fill_next;
  logic [FW-1:0] p, p_next;
  logic [1:0]    k, k_next;
  logic [FW-1:0] h, h_next;
  logic [FW-1:0] off, off_next;
  logic [FW-1:0] len, len_next;
  logic [FW-1:0] i, i_next;
  logic          phase_tail, phase_tail_next;
  logic          res_valid_next;
  result_t       res_next;

  logic [2:0] hl, tl, plen;
  logic [6:0] fl;
  logic [7:0] pat_byte;
  logic [CW-1:0] fill_c;
  logic       over, byte_eq, match_done, emit_last, len_cond;
  logic [CW-1:0] end_pos;

  // Map an offset from the oldest byte to a store address.
  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = {{(CW+1-AW){1'b0}}, base} + {1'b0, ofs};
    if (sum >= {1'b0, DEPTH_C}) begin
      sum = sum - {1'b0, DEPTH_C};
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [2:0] clamp_len(input logic [2:0] n);
    if (n == 3'd0) begin
      return 3'd1;
    end else if (n > 3'(PATTERN_BYTES)) begin
      return 3'(PATTERN_BYTES);
    end
    return n;
  endfunction

  assign hl       = clamp_len(cfg.head_length);
  assign tl       = clamp_len(cfg.tail_length);
  assign fl       = (cfg.frame_length == 7'd0) ? 7'd1 : cfg.frame_length;
  assign plen     = phase_tail ? tl : hl;
  assign pat_byte = phase_tail ? cfg.tail_pattern[8*k +: 8] : cfg.head_pattern[8*k +: 8];
  assign fill_c   = CW'(fill);
  assign over     = (CW'(p) + CW'(plen)) > fill_c;
  assign byte_eq  = (rdata == pat_byte);
  assign match_done = byte_eq && ({1'b0, k} + 3'd1 == plen);
  assign len_cond = (fill_c - CW'(p)) >= CW'(fl);
  assign emit_last = (i + FW'(1) == len);
  assign end_pos  = CW'(off) + CW'(len);
  assign pop      = (state == ST_IDLE) && head.valid;

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= head.item.in_byte;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    if (state == ST_ERD) begin
      raddr = addr_of(start_ptr, CW'(off) + CW'(i));
    end else begin
      raddr = addr_of(start_ptr, CW'(p) + CW'(k));
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid && head.item.cmd == CMD_EXTRACT) begin
          case (cfg.rule_mode)
            RULE_ALL:       state_next = (fill == '0) ? ST_IDLE : ST_ERD;
            RULE_HEAD_TAIL: state_next = ST_CHK;
            RULE_HEAD_LEN:  state_next = ST_CHK;
            RULE_TAIL:      state_next = ST_CHK;
            RULE_LEN:       state_next = (fill_c >= CW'(fl)) ? ST_ERD : ST_IDLE;
            default:        state_next = ST_IDLE;
          endcase
        end
      end
      ST_CHK: state_next = over ? ST_IDLE : ST_RD;
      ST_RD:  state_next = ST_CMP;
      ST_CMP: begin
        if (!byte_eq) begin
          state_next = ST_CHK;
        end else if (!match_done) begin
          state_next = ST_RD;
        end else if (phase_tail) begin
          state_next = ST_ERD;
        end else if (cfg.rule_mode == RULE_HEAD_TAIL) begin
          state_next = ST_CHK;
        end else begin
          state_next = len_cond ? ST_ERD : ST_IDLE;
        end
      end
      ST_ERD:  state_next = ST_EOUT;
      ST_EOUT: state_next = emit_last ? ST_IDLE : ST_ERD;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and result values.
  always_comb begin
    start_ptr_next  = start_ptr;
    fill_next       = fill;
    p_next          = p;
    k_next          = k;
    h_next          = h;
    off_next        = off;
    len_next        = len;
    i_next          = i;
    phase_tail_next = phase_tail;
    we              = 1'b0;
    waddr           = addr_of(start_ptr, fill_c);
    res_valid_next  = 1'b0;
    res_next        = '0;
    res_next.last   = 1'b1;
    res_next.fill_level = fill_c[6:0];
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          i_next = '0;
          p_next = '0;
          case (head.item.cmd)
            CMD_APPEND: begin
              we = 1'b1;
              res_valid_next = 1'b1;
              if (fill_c >= DEPTH_C) begin
                // Full: overwrite the oldest byte and advance past it.
                waddr = start_ptr;
                start_ptr_next = addr_of(start_ptr, CW'(1));
                res_next.overflow_dropped = 1'b1;
              end else begin
                fill_next = fill + FW'(1);
                res_next.fill_level = 7'(fill_c + CW'(1));
              end
            end
            CMD_REMOVE: begin
              res_valid_next = 1'b1;
              if (CW'(head.item.remove_count) >= fill_c) begin
                start_ptr_next = '0;
                fill_next = '0;
                res_next.fill_level = '0;
              end else begin
                start_ptr_next = addr_of(start_ptr, CW'(head.item.remove_count));
                fill_next = FW'(fill_c - CW'(head.item.remove_count));
                res_next.fill_level = 7'(fill_c - CW'(head.item.remove_count));
              end
            end
            CMD_CLEAR: begin
              res_valid_next = 1'b1;
              start_ptr_next = '0;
              fill_next = '0;
              res_next.fill_level = '0;
            end
            default: begin
              case (cfg.rule_mode)
                RULE_ALL: begin
                  off_next = '0;
                  len_next = fill;
                  if (fill == '0) begin
                    // Empty buffer: a found frame with no bytes.
                    res_valid_next = 1'b1;
                    res_next.frame_found = 1'b1;
                    start_ptr_next = '0;
                  end
                end
                RULE_HEAD_TAIL, RULE_HEAD_LEN: begin
                  phase_tail_next = 1'b0;
                end
                RULE_TAIL: begin
                  phase_tail_next = 1'b1;
                end
                RULE_LEN: begin
                  off_next = '0;
                  len_next = FW'(fl);
                  res_valid_next = !(fill_c >= CW'(fl));
                end
                default: begin
                  res_valid_next = 1'b1;
                end
              endcase
            end
          endcase
        end
      end
      ST_CHK: begin
        k_next = '0;
        res_valid_next = over;
      end
      ST_CMP: begin
        if (!byte_eq) begin
          p_next = p + FW'(1);
        end else if (!match_done) begin
          k_next = k + 2'd1;
        end else if (phase_tail) begin
          if (cfg.rule_mode == RULE_HEAD_TAIL) begin
            off_next = h;
            len_next = FW'(CW'(p) + CW'(tl) - CW'(h));
          end else begin
            off_next = '0;
            len_next = FW'(CW'(p) + CW'(tl));
          end
        end else begin
          h_next = p;
          if (cfg.rule_mode == RULE_HEAD_TAIL) begin
            phase_tail_next = 1'b1;
            p_next = FW'(CW'(p) + CW'(hl));
          end else begin
            off_next = p;
            len_next = FW'(fl);
            res_valid_next = !len_cond;
          end
        end
      end
      ST_EOUT: begin
        res_valid_next = 1'b1;
        res_next.out_byte = rdata;
        res_next.byte_valid = 1'b1;
        res_next.frame_found = 1'b1;
        res_next.last = emit_last;
        res_next.fill_level = 7'(fill_c - end_pos);
        i_next = i + FW'(1);
        if (emit_last) begin
          if (end_pos == fill_c) begin
            start_ptr_next = '0;
            fill_next = '0;
          end else begin
            start_ptr_next = addr_of(start_ptr, end_pos);
            fill_next = FW'(fill_c - end_pos);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      start_ptr    <= '0;
      fill         <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      start_ptr    <= start_ptr_next;
      fill         <= fill_next;
      result_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    p          <= p_next;
    k          <= k_next;
    h          <= h_next;
    off        <= off_next;
    len        <= len_next;
    i          <= i_next;
    phase_tail <= phase_tail_next;
    result     <= res_next;
  end

  // The fill never exceeds the store depth.
  assert property (@(posedge clk) disable iff (rst) fill_c <= DEPTH_C)
    else $error("fill above depth");
  // A result that is not the last one of its command always carries a frame byte.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> result.byte_valid)
    else $error("non-final result without data");
  // A frame byte is emitted in the cycle after its read is issued.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EOUT) |-> $past(state == ST_ERD))
    else $error("emit without read");
  // Commands are only taken while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst) pop |-> state == ST_IDLE)
    else $error("pop while busy");

endmodule

// ===== rtl/byte_buffer_frame_extractor.sv =====
// Top level of the byte buffer frame extractor: configuration registers, front queue, back end.
// Depends on bbfe_pkg, bbfe_front and bbfe_back.
//
// Commands are taken when start is high and busy is low; a two-entry queue lets a new command
// in while the back end works. Append, remove and clear each give one registered result in the
// next cycle, so a steady append stream runs at one per cycle. Extract is run by a sequencer over
// the byte store (one write port, one registered read port): each candidate position passes a
// check state, then a read and a compare state for every pattern byte compared, and each frame
// byte goes through a read and an emit state. Results appear on result for one cycle with
// result_valid high and cannot be held off. Configuration is written through cfg_we, cfg_index
// and cfg_data only while the block is idle; the user must ensure this, the block does not.
module byte_buffer_frame_extractor #(
  parameter int BUF_DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  bbfe_pkg::cmd_item_t                    in_item,
  output logic                                   result_valid,
  output bbfe_pkg::result_t                      result,
  input  logic                                   cfg_we,
  input  logic [bbfe_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [bbfe_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import bbfe_pkg::*;

  cfg_t        cfg;
  queue_head_t head;
  logic        pop;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rule_mode    <= RULE_ALL;
      cfg.head_pattern <= '0;
      cfg.head_length  <= 3'd1;
      cfg.tail_pattern <= '0;
      cfg.tail_length  <= 3'd1;
      cfg.frame_length <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RULE_MODE:    cfg.rule_mode    <= cfg_data[2:0];
        REG_HEAD_PATTERN: cfg.head_pattern <= cfg_data;
        REG_HEAD_LENGTH:  cfg.head_length  <= cfg_data[2:0];
        REG_TAIL_PATTERN: cfg.tail_pattern <= cfg_data;
        REG_TAIL_LENGTH:  cfg.tail_length  <= cfg_data[2:0];
        REG_FRAME_LENGTH: cfg.frame_length <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  bbfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .head    (head),
    .pop     (pop)
  );

  bbfe_back #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
